[rtl/cascaded_position_speed_pid_top_defines.svh]
// Assertion macros shared by the checker of the cascaded position/speed PID block.
// Holds only macro definitions; no other file dependencies.
`ifndef CASCADED_POSITION_SPEED_PID_TOP_DEFINES_SVH
`define CASCADED_POSITION_SPEED_PID_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpsp check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CPSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpsp check failed");

`endif

[rtl/cpsp_pkg.sv]
// Types and constants of the cascaded position/speed PID block.
// No dependencies; used by the interfaces, the top level and the checker.
package cpsp_pkg;

    typedef logic [2:0] t_reg_idx;
    typedef logic [1:0] t_mode;

    localparam t_reg_idx REG_POS_KP    = 3'd0;
    localparam t_reg_idx REG_POS_KI    = 3'd1;
    localparam t_reg_idx REG_POS_KD    = 3'd2;
    localparam t_reg_idx REG_SPD_KP    = 3'd3;
    localparam t_reg_idx REG_SPD_KI    = 3'd4;
    localparam t_reg_idx REG_SPD_KD    = 3'd5;
    localparam t_reg_idx REG_SPEED_DIV = 3'd6;

    localparam logic [15:0] RST_POS_KP    = 16'd128;
    localparam logic [15:0] RST_POS_KI    = 16'd26;
    localparam logic [15:0] RST_POS_KD    = 16'd51;
    localparam logic [15:0] RST_SPD_KP    = 16'd77;
    localparam logic [15:0] RST_SPD_KI    = 16'd13;
    localparam logic [15:0] RST_SPD_KD    = 16'd26;
    localparam logic [15:0] RST_SPEED_DIV = 16'd1;

    localparam t_mode MODE_FULL = 2'd0;
    localparam t_mode MODE_PID  = 2'd1;
    localparam t_mode MODE_STOP = 2'd2;

    localparam logic signed [16:0] FULL_LIMIT  = 17'sd15000;
    localparam logic signed [16:0] STOP_LIMIT  = 17'sd10000;
    localparam logic [6:0]         SPD_INT_MAX = 7'd100;

endpackage

[rtl/cpsp_if.sv]
// Valid/ready channel interfaces of the cascaded position/speed PID block.
// Depends on cpsp_pkg for the register index and mode types.
interface cpsp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] target_position;
    logic [15:0] current_position;

    modport source (output valid, output target_position, output current_position,
                    input ready);
    modport sink   (input valid, input target_position, input current_position,
                    output ready);
endinterface

interface cpsp_out_if;
    logic              valid;
    logic              ready;
    cpsp_pkg::t_mode   drive_mode;
    logic [15:0]       drive_value;

    modport source (output valid, output drive_mode, output drive_value, input ready);
    modport sink   (input valid, input drive_mode, input drive_value, output ready);
endinterface

interface cpsp_cfg_if;
    logic               valid;
    logic               ready;
    cpsp_pkg::t_reg_idx index;
    logic [15:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/cascaded_position_speed_pid_top.sv]
// Cascaded position/speed PID: one word in, one word out, shared multiply-accumulate unit.
// Full drive or stop: the result is valid in the cycle after the input word is accepted.
// PID mode: PINT, PMAC, PCHK, a 16-step divider (skipped if the position sum is not positive
// or the speed target saturates), SERR, SMAC and SOUT; six passes through the single multiplier.
// A new word can be accepted the cycle after the result word is taken.
// Synchronous active-low reset restores gains and clears all loop state.
module cascaded_position_speed_pid_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cpsp_in_if.sink           i_in,
    cpsp_out_if.source        o_out,
    cpsp_cfg_if.sink          i_cfg
);
    import cpsp_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_PINT = 9'b000000010,
        ST_PMAC = 9'b000000100,
        ST_PCHK = 9'b000001000,
        ST_DIV  = 9'b000010000,
        ST_SERR = 9'b000100000,
        ST_SMAC = 9'b001000000,
        ST_SOUT = 9'b010000000,
        ST_OUT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [15:0] r_pos_kp, r_pos_ki, r_pos_kd;
    logic [15:0] r_spd_kp, r_spd_ki, r_spd_kd;
    logic [15:0] r_speed_div;

    logic signed [31:0] r_pos_int;
    logic signed [16:0] r_pos_prev;
    logic        [6:0]  r_spd_int;
    logic signed [16:0] r_spd_prev;
    logic        [15:0] r_spd_fb;

    logic signed [16:0] r_pos_err;
    logic signed [16:0] r_es;
    logic signed [49:0] r_acc;
    logic        [1:0]  r_step;
    logic        [3:0]  r_cnt;
    logic        [15:0] r_rem;
    logic        [15:0] r_quo;
    t_mode              r_mode;
    logic        [15:0] r_drive;

    logic signed [16:0] w_err;
    logic signed [32:0] w_int_sum;
    logic signed [17:0] w_pos_diff;
    logic signed [17:0] w_spd_diff;
    logic        [15:0] w_mac_gain;
    logic signed [32:0] w_mac_op;
    logic signed [49:0] w_prod;
    logic        [15:0] w_div;
    logic        [40:0] w_num;
    logic               w_acc_nonpos;
    logic        [16:0] w_trial;
    logic               w_qbit;
    logic signed [16:0] w_es;
    logic        [17:0] w_sint;
    logic        [15:0] w_drive;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = (r_state == ST_OUT);
    assign o_out.drive_mode  = r_mode;
    assign o_out.drive_value = r_drive;
    assign i_cfg.ready = 1'b1;

    assign w_err = $signed({1'b0, i_in.target_position})
                 - $signed({1'b0, i_in.current_position});
    assign w_int_sum  = {r_pos_int[31], r_pos_int} + {{16{r_pos_err[16]}}, r_pos_err};
    assign w_pos_diff = {r_pos_err[16], r_pos_err} - {r_pos_prev[16], r_pos_prev};
    assign w_spd_diff = {r_es[16], r_es} - {r_spd_prev[16], r_spd_prev};

    // Operand selection for the shared multiplier: P, I and D terms in turn.
    always_comb begin
        w_mac_gain = r_pos_kp;
        w_mac_op   = {{16{r_pos_err[16]}}, r_pos_err};
        if (r_state == ST_SMAC) begin
            unique case (r_step)
                2'd0: begin
                    w_mac_gain = r_spd_kp;
                    w_mac_op   = {{16{r_es[16]}}, r_es};
                end
                2'd1: begin
                    w_mac_gain = r_spd_ki;
                    w_mac_op   = {26'd0, r_spd_int};
                end
                default: begin
                    w_mac_gain = r_spd_kd;
                    w_mac_op   = {{15{w_spd_diff[17]}}, w_spd_diff};
                end
            endcase
        end else begin
            unique case (r_step)
                2'd0: begin
                    w_mac_gain = r_pos_kp;
                    w_mac_op   = {{16{r_pos_err[16]}}, r_pos_err};
                end
                2'd1: begin
                    w_mac_gain = r_pos_ki;
                    w_mac_op   = {r_pos_int[31], r_pos_int};
                end
                default: begin
                    w_mac_gain = r_pos_kd;
                    w_mac_op   = {{15{w_pos_diff[17]}}, w_pos_diff};
                end
            endcase
        end
    end

    assign w_prod = $signed({1'b0, w_mac_gain}) * w_mac_op;

    assign w_div        = (r_speed_div == 16'd0) ? 16'd1 : r_speed_div;
    assign w_num        = r_acc[48:8];
    assign w_acc_nonpos = r_acc[49] || (r_acc == '0);

    // One restoring division step: shift in the next numerator bit, subtract if it fits.
    assign w_trial = {r_rem, r_quo[15]};
    assign w_qbit  = (w_trial >= {1'b0, w_div});

    assign w_es   = $signed({1'b0, r_quo}) - $signed({1'b0, r_spd_fb});
    assign w_sint = {{11{1'b0}}, r_spd_int} + {w_es[16], w_es};

    always_comb begin
        if (w_acc_nonpos) begin
            w_drive = 16'd0;
        end else if (|r_acc[48:24]) begin
            w_drive = 16'hFFFF;
        end else begin
            w_drive = r_acc[23:8];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    if (w_err > FULL_LIMIT || w_err <= STOP_LIMIT) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_PINT;
                    end
                end
            end
            ST_PINT: n_state = ST_PMAC;
            ST_PMAC: if (r_step == 2'd2) n_state = ST_PCHK;
            ST_PCHK: begin
                if (w_acc_nonpos || w_num >= {9'd0, w_div, 16'd0}) begin
                    n_state = ST_SERR;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV:  if (r_cnt == 4'd15) n_state = ST_SERR;
            ST_SERR: n_state = ST_SMAC;
            ST_SMAC: if (r_step == 2'd2) n_state = ST_SOUT;
            ST_SOUT: n_state = ST_OUT;
            ST_OUT:  if (o_out.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_kp    <= RST_POS_KP;
            r_pos_ki    <= RST_POS_KI;
            r_pos_kd    <= RST_POS_KD;
            r_spd_kp    <= RST_SPD_KP;
            r_spd_ki    <= RST_SPD_KI;
            r_spd_kd    <= RST_SPD_KD;
            r_speed_div <= RST_SPEED_DIV;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_POS_KP:    r_pos_kp    <= i_cfg.data;
                REG_POS_KI:    r_pos_ki    <= i_cfg.data;
                REG_POS_KD:    r_pos_kd    <= i_cfg.data;
                REG_SPD_KP:    r_spd_kp    <= i_cfg.data;
                REG_SPD_KI:    r_spd_ki    <= i_cfg.data;
                REG_SPD_KD:    r_spd_kd    <= i_cfg.data;
                REG_SPEED_DIV: r_speed_div <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Loop state: only PID ticks change it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_int  <= '0;
            r_pos_prev <= '0;
            r_spd_int  <= '0;
            r_spd_prev <= '0;
            r_spd_fb   <= '0;
            r_step     <= '0;
            r_cnt      <= '0;
        end else begin
            unique case (r_state)
                ST_PINT: begin
                    if (w_int_sum[32] != w_int_sum[31]) begin
                        r_pos_int <= w_int_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
                    end else begin
                        r_pos_int <= w_int_sum[31:0];
                    end
                    r_step <= 2'd0;
                end
                ST_PMAC, ST_SMAC: r_step <= (r_step == 2'd2) ? 2'd0 : r_step + 2'd1;
                ST_PCHK: begin
                    r_pos_prev <= r_pos_err;
                    r_cnt      <= 4'd0;
                end
                ST_DIV:  r_cnt <= r_cnt + 4'd1;
                ST_SERR: begin
                    if (w_sint[17]) begin
                        r_spd_int <= 7'd0;
                    end else if (w_sint[16:0] > {10'd0, SPD_INT_MAX}) begin
                        r_spd_int <= SPD_INT_MAX;
                    end else begin
                        r_spd_int <= w_sint[6:0];
                    end
                    r_step <= 2'd0;
                end
                ST_SOUT: begin
                    r_spd_prev <= r_es;
                    r_spd_fb   <= w_drive;
                end
                default: ;
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_pos_err <= w_err;
                r_acc     <= '0;
                r_drive   <= 16'd0;
                if (w_err > FULL_LIMIT) begin
                    r_mode <= MODE_FULL;
                end else if (w_err <= STOP_LIMIT) begin
                    r_mode <= MODE_STOP;
                end else begin
                    r_mode <= MODE_PID;
                end
            end
            ST_PMAC, ST_SMAC: r_acc <= r_acc + w_prod;
            ST_PCHK: begin
                // The quotient holds at most 16 bits here, so the upper numerator
                // bits fit below the divisor and seed the remainder.
                if (w_acc_nonpos) begin
                    r_quo <= 16'd0;
                end else if (w_num >= {9'd0, w_div, 16'd0}) begin
                    r_quo <= 16'hFFFF;
                end else begin
                    r_rem <= w_num[31:16];
                    r_quo <= w_num[15:0];
                end
            end
            ST_DIV: begin
                r_rem <= w_qbit ? 16'(w_trial - {1'b0, w_div}) : w_trial[15:0];
                r_quo <= {r_quo[14:0], w_qbit};
            end
            ST_SERR: begin
                r_es  <= w_es;
                r_acc <= '0;
            end
            ST_SOUT: r_drive <= w_drive;
            default: ;
        endcase
    end

endmodule

[rtl/cpsp_checker.sv]
// Port-level checks of the cascaded position/speed PID block, bound to its top level.
// Depends on cpsp_pkg and the assertion macros in the defines header.
`include "cascaded_position_speed_pid_top_defines.svh"

module cpsp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input cpsp_pkg::t_mode     i_drive_mode,
    input logic [15:0]         i_drive_value
);
    import cpsp_pkg::*;

    // A result word that is not taken stays offered unchanged.
    `CPSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_drive_mode) && $stable(i_drive_value))

    // The block never takes a new word while a result is pending.
    `CPSP_ASSERT_NOW(a_busy_while_out, i_clk, i_rst_n, i_out_valid, !i_in_ready)

    // Taking an input word lowers ready.
    `CPSP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // Full drive and stop carry a zero drive level; no undefined mode code appears.
    `CPSP_ASSERT_NOW(a_mode_value, i_clk, i_rst_n, i_out_valid, (i_drive_mode == MODE_PID) || ((i_drive_mode == MODE_FULL || i_drive_mode == MODE_STOP) && i_drive_value == 16'd0))

endmodule

bind cascaded_position_speed_pid_top cpsp_checker u_cpsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_drive_mode  (o_out.drive_mode),
    .i_drive_value (o_out.drive_value)
);

[dv/tb_cascaded_position_speed_pid_top.sv]
// Self-checking testbench for the cascaded position/speed PID top level.
// Depends on cpsp_pkg, the cpsp channel interfaces and cascaded_position_speed_pid_top;
// every word is checked against the directed table or a cycle-free model of both control loops.
module tb_cascaded_position_speed_pid_top;
    import cpsp_pkg::*;

    localparam int       NUM_GAIN_REGS = 7;
    localparam t_reg_idx REG_UNMAPPED  = 3'd7;
    localparam int       NUM_PHASES    = 6;
    localparam int       TICKS_PER_SET = 65;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] value;
    } t_drive_word;

    typedef struct packed {
        logic [15:0] tgt;
        logic [15:0] cur;
        logic        known;
        t_mode       mode;
        logic [15:0] value;
    } t_tick_row;

    logic i_clk;
    logic i_rst_n;

    cpsp_in_if  in_ch ();
    cpsp_out_if out_ch ();
    cpsp_cfg_if cfg_ch ();

    cascaded_position_speed_pid_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Loop state and gain registers as the block should hold them.
    logic [15:0] gain_reg [NUM_GAIN_REGS];
    int          pos_sum;
    int          pos_last_err;
    int          spd_sum;
    int          spd_last_err;
    logic [15:0] last_drive;

    t_drive_word drive_q [$];
    int          mismatch_count;
    int          send_gap_pct;
    int          take_stall_pct;

    // Mode boundaries and field extremes. Rows marked known carry their result;
    // the PID rows are left to the loop model.
    t_tick_row tick_table [0:20] = '{
        '{16'd0,     16'd0,     1'b1, MODE_STOP, 16'd0},
        '{16'd65535, 16'd0,     1'b1, MODE_FULL, 16'd0},
        '{16'd0,     16'd65535, 1'b1, MODE_STOP, 16'd0},
        '{16'd65535, 16'd65535, 1'b1, MODE_STOP, 16'd0},
        '{16'd15001, 16'd0,     1'b1, MODE_FULL, 16'd0},
        '{16'd15000, 16'd0,     1'b0, MODE_PID,  16'd0},
        '{16'd10000, 16'd0,     1'b1, MODE_STOP, 16'd0},
        '{16'd10001, 16'd0,     1'b0, MODE_PID,  16'd0},
        '{16'd65535, 16'd50535, 1'b0, MODE_PID,  16'd0},
        '{16'd65535, 16'd50534, 1'b1, MODE_FULL, 16'd0},
        '{16'd20000, 16'd9999,  1'b0, MODE_PID,  16'd0},
        '{16'd20000, 16'd10000, 1'b1, MODE_STOP, 16'd0},
        '{16'd12345, 16'd1000,  1'b0, MODE_PID,  16'd0},
        '{16'd14000, 16'd2000,  1'b0, MODE_PID,  16'd0},
        '{16'd11000, 16'd0,     1'b0, MODE_PID,  16'd0},
        '{16'd32768, 16'd21845, 1'b0, MODE_PID,  16'd0},
        '{16'd43690, 16'd30000, 1'b0, MODE_PID,  16'd0},
        '{16'd21845, 16'd43690, 1'b1, MODE_STOP, 16'd0},
        '{16'd65535, 16'd55535, 1'b1, MODE_STOP, 16'd0},
        '{16'd55536, 16'd40535, 1'b1, MODE_FULL, 16'd0},
        '{16'd40000, 16'd27000, 1'b0, MODE_PID,  16'd0}
    };

    function automatic logic [15:0] clip_quotient(input longint sum, input longint dvs);
        longint q;
        if (sum <= 0)
            return 16'd0;
        q = sum / dvs;
        return (q > 65535) ? 16'hFFFF : q[15:0];
    endfunction

    // One control tick: mode select, then position loop feeding the speed loop.
    function automatic t_drive_word step_cascade(input logic [15:0] tgt, input logic [15:0] cur);
        int          err;
        int          spd_err;
        longint      acc;
        longint      sum;
        longint      dvs;
        logic [15:0] spd_target;
        t_drive_word w;
        err     = int'(tgt) - int'(cur);
        w.value = 16'd0;
        if (err > int'(FULL_LIMIT)) begin
            w.mode = MODE_FULL;
            return w;
        end
        if (err <= int'(STOP_LIMIT)) begin
            w.mode = MODE_STOP;
            return w;
        end
        acc = longint'(pos_sum) + err;
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        pos_sum = int'(acc);
        sum = longint'(gain_reg[REG_POS_KP]) * err
            + longint'(gain_reg[REG_POS_KI]) * pos_sum
            + longint'(gain_reg[REG_POS_KD]) * (longint'(err) - pos_last_err);
        pos_last_err = err;
        // A divisor of zero behaves as one.
        dvs = (gain_reg[REG_SPEED_DIV] == 16'd0) ? 64'sd256
                                                  : longint'(gain_reg[REG_SPEED_DIV]) * 256;
        spd_target = clip_quotient(sum, dvs);

        spd_err = int'(spd_target) - int'(last_drive);
        spd_sum = spd_sum + spd_err;
        if (spd_sum > int'(SPD_INT_MAX))
            spd_sum = int'(SPD_INT_MAX);
        if (spd_sum < 0)
            spd_sum = 0;
        sum = longint'(gain_reg[REG_SPD_KP]) * spd_err
            + longint'(gain_reg[REG_SPD_KI]) * spd_sum
            + longint'(gain_reg[REG_SPD_KD]) * (longint'(spd_err) - spd_last_err);
        spd_last_err = spd_err;
        w.value    = clip_quotient(sum, 256);
        last_drive = w.value;
        w.mode     = MODE_PID;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t mismatch, %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Leaves valid high on return, so the caller lowers it once the burst is over.
    task automatic write_reg(input t_reg_idx idx, input logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge i_clk);
        if (idx < NUM_GAIN_REGS)
            gain_reg[idx] = val;
    endtask

    task automatic load_gains(input logic [15:0] g [NUM_GAIN_REGS]);
        for (int i = 0; i < NUM_GAIN_REGS; i++)
            write_reg(t_reg_idx'(i), g[i]);
        // Unmapped index: the block must drop this write.
        write_reg(REG_UNMAPPED, 16'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // Valid stays high from one word to the next unless a gap is drawn.
    task automatic send_tick(input logic [15:0] tgt, input logic [15:0] cur,
                             input logic known, input t_drive_word fixed);
        t_drive_word w;
        while ($urandom_range(99) < send_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.target_position  <= tgt;
        in_ch.current_position <= cur;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1)
            @(posedge i_clk);
        w = step_cascade(tgt, cur);
        drive_q.push_back(known ? fixed : w);
    endtask

    // Mostly distances inside the PID band, so the loops build up history.
    task automatic random_ticks(input int count);
        int          span;
        logic [15:0] tgt;
        logic [15:0] cur;
        repeat (count) begin
            case ($urandom_range(9))
                0, 1: begin
                    tgt  = 16'($urandom);
                    cur  = 16'($urandom);
                    span = -1;
                end
                2: begin
                    case ($urandom_range(3))
                        0: span = 10000;
                        1: span = 10001;
                        2: span = 15000;
                        default: span = 15001;
                    endcase
                end
                default: span = $urandom_range(15000, 10001);
            endcase
            if (span >= 0) begin
                cur = 16'($urandom_range(65535 - span));
                tgt = 16'(int'(cur) + span);
            end
            send_tick(tgt, cur, 1'b0, '0);
        end
    endtask

    task automatic wait_idle();
        while (drive_q.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_cascaded_position_speed_pid_top NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin : take_words
        t_drive_word want;
        out_ch.ready <= ($urandom_range(99) >= take_stall_pct);
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (drive_q.size() == 0) begin
                report_mismatch("word with nothing expected", 16'(out_ch.drive_mode), 16'd0);
            end else begin
                want = drive_q.pop_front();
                if (out_ch.drive_mode !== want.mode)
                    report_mismatch("drive_mode", 16'(out_ch.drive_mode), 16'(want.mode));
                if (out_ch.drive_value !== want.value)
                    report_mismatch("drive_value", out_ch.drive_value, want.value);
            end
        end
    end

    initial begin : stimulus
        logic [15:0] g [NUM_GAIN_REGS];
        t_drive_word fixed;

        gain_reg[REG_POS_KP]    = RST_POS_KP;
        gain_reg[REG_POS_KI]    = RST_POS_KI;
        gain_reg[REG_POS_KD]    = RST_POS_KD;
        gain_reg[REG_SPD_KP]    = RST_SPD_KP;
        gain_reg[REG_SPD_KI]    = RST_SPD_KI;
        gain_reg[REG_SPD_KD]    = RST_SPD_KD;
        gain_reg[REG_SPEED_DIV] = RST_SPEED_DIV;
        pos_sum        = 0;
        pos_last_err   = 0;
        spd_sum        = 0;
        spd_last_err   = 0;
        last_drive     = 16'd0;
        mismatch_count = 0;
        send_gap_pct   = 29;
        take_stall_pct = 63;

        i_rst_n                <= 1'b0;
        in_ch.valid            <= 1'b0;
        in_ch.target_position  <= 16'd0;
        in_ch.current_position <= 16'd0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.index           <= REG_POS_KP;
        cfg_ch.data            <= 16'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset gains first: directed rows, then random ticks.
        foreach (tick_table[i]) begin
            fixed.mode  = tick_table[i].mode;
            fixed.value = tick_table[i].value;
            send_tick(tick_table[i].tgt, tick_table[i].cur, tick_table[i].known, fixed);
        end
        random_ticks(40);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            in_ch.valid <= 1'b0;
            wait_idle();
            for (int i = 0; i < NUM_GAIN_REGS; i++) begin
                case (ph)
                    0: g[i] = 16'hFFFF;
                    1: g[i] = 16'd0;
                    2: g[i] = 16'($urandom_range(600));
                    3: g[i] = 16'($urandom);
                    default: g[i] = 16'd0;
                endcase
            end
            case (ph)
                2: g[REG_SPEED_DIV] = 16'($urandom_range(8, 1));
                4: begin
                    // Derivative-only position loop: a falling error zeroes the speed target.
                    g[REG_POS_KD]    = 16'hFFFF;
                    g[REG_SPD_KP]    = 16'd300;
                    g[REG_SPD_KI]    = 16'd13;
                    g[REG_SPD_KD]    = 16'hFFFF;
                    g[REG_SPEED_DIV] = 16'd1;
                end
                5: begin
                    g[REG_POS_KP]    = RST_POS_KP;
                    g[REG_POS_KI]    = RST_POS_KI;
                    g[REG_POS_KD]    = RST_POS_KD;
                    g[REG_SPD_KP]    = RST_SPD_KP;
                    g[REG_SPD_KI]    = RST_SPD_KI;
                    g[REG_SPD_KD]    = RST_SPD_KD;
                    g[REG_SPEED_DIV] = RST_SPEED_DIV;
                end
                default: ;
            endcase
            if (ph < 2) begin
                send_gap_pct   = 29;
                take_stall_pct = 63;
            end else if (ph < 4) begin
                send_gap_pct   = 63;
                take_stall_pct = 29;
            end else begin
                send_gap_pct   = 0;
                take_stall_pct = 0;
            end
            load_gains(g);
            random_ticks(TICKS_PER_SET);
        end

        in_ch.valid <= 1'b0;
        wait_idle();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb_cascaded_position_speed_pid_top OK");
        else
            $display("tb_cascaded_position_speed_pid_top NOT OK");
        $finish;
    end

endmodule
